### src/bcpe_pkg.sv
// Shared types, constants and the sequencer microcode for the Bezier point evaluator.
`timescale 1ns / 1ps
package bcpe_pkg;

	// Field widths of the channel words and the register port
	localparam int POINT_W    = 10;
	localparam int T_W        = 17;
	localparam int CURVE_W    = 18;
	localparam int STATUS_W   = 2;
	localparam int HELD_W     = 5;
	localparam int SH_W       = 10;
	localparam int FRAC_BITS  = 8;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [T_W-1:0]  T_ONE    = 17'h10000;
	localparam logic [SH_W-1:0] SH_RESET = 10'd480;

	// Register index as decoded from paddr
	localparam logic REG_WIN_HEIGHT = 1'b0;

	// Request kinds
	localparam logic REQ_ADD  = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FEW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	// Microcode
	localparam int STEP_W = 3;

	localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
	localparam logic [STEP_W-1:0] STEP_DECODE = 3'd1;
	localparam logic [STEP_W-1:0] STEP_ROUND  = 3'd2;
	localparam logic [STEP_W-1:0] STEP_INNER  = 3'd3;
	localparam logic [STEP_W-1:0] STEP_DRAIN  = 3'd4;
	localparam logic [STEP_W-1:0] STEP_RNDEND = 3'd5;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd6;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_DECODE,
		OP_ISSUE_A,
		OP_ISSUE_LERP,
		OP_NEXT_ROUND,
		OP_EMIT
	} uop_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_ACCEPT,
		C_NOT_EVAL,
		C_IDX_LAST,
		C_MORE_ROUNDS,
		C_OUT_FREE
	} ucond_t;

	// cond true -> target; else hold -> same step; else step + 1
	typedef struct packed {
		uop_t              op;
		ucond_t            cond;
		logic              hold;
		logic [STEP_W-1:0] target;
	} uword_t;

	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
		uword_t w;
		unique case (step)
			STEP_IDLE:   w = '{op: OP_NONE,       cond: C_ACCEPT,      hold: 1'b1,
				target: STEP_DECODE};
			STEP_DECODE: w = '{op: OP_DECODE,     cond: C_NOT_EVAL,    hold: 1'b0,
				target: STEP_EMIT};
			STEP_ROUND:  w = '{op: OP_ISSUE_A,    cond: C_NEXT,        hold: 1'b0,
				target: STEP_IDLE};
			STEP_INNER:  w = '{op: OP_ISSUE_LERP, cond: C_IDX_LAST,    hold: 1'b1,
				target: STEP_DRAIN};
			STEP_DRAIN:  w = '{op: OP_NONE,       cond: C_NEXT,        hold: 1'b0,
				target: STEP_IDLE};
			STEP_RNDEND: w = '{op: OP_NEXT_ROUND, cond: C_MORE_ROUNDS, hold: 1'b0,
				target: STEP_ROUND};
			STEP_EMIT:   w = '{op: OP_EMIT,       cond: C_OUT_FREE,    hold: 1'b1,
				target: STEP_IDLE};
			default:     w = '{op: OP_NONE,       cond: C_ALWAYS,      hold: 1'b0,
				target: STEP_IDLE};
		endcase
		return w;
	endfunction

endpackage

### src/bcpe_if.sv
// Request and response channel interfaces of the Bezier point evaluator.
`timescale 1ns / 1ps
interface bcpe_req_if;
	import bcpe_pkg::*;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [POINT_W-1:0] point_x;
	logic [POINT_W-1:0] point_y;
	logic [T_W-1:0]     t_frac;

	modport source (output valid, req_type, point_x, point_y, t_frac, input ready);
	modport sink   (input valid, req_type, point_x, point_y, t_frac, output ready);
endinterface

interface bcpe_rsp_if;
	import bcpe_pkg::*;

	logic                valid;
	logic                ready;
	logic [CURVE_W-1:0]  curve_x;
	logic [CURVE_W-1:0]  curve_y;
	logic [STATUS_W-1:0] status;
	logic [HELD_W-1:0]   points_held;

	modport source (output valid, curve_x, curve_y, status, points_held, input ready);
	modport sink   (input valid, curve_x, curve_y, status, points_held, output ready);
endinterface

### src/bezier_curve_point_evaluator_core.sv
// Bezier curve point evaluator: microcoded de Casteljau engine with control point store.
// Add and rejected requests: decode goes straight to the emit step, which registers the word and returns to idle.
// Evaluate over n points: the inner step issues one lerp per cycle per axis through the work memory,
// and each round also passes through the round, drain and round-end steps.
// One request at a time; a word held back by the sink stalls the sequencer in its emit step.
// Reset clears the point count and sequencer, the window height returns to 480.
`timescale 1ns / 1ps
module bezier_curve_point_evaluator_core #(
	parameter int MAX_POINTS = 16,
	parameter int COORD_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	bcpe_req_if.sink                        req,
	bcpe_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bcpe_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bcpe_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bcpe_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import bcpe_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int W     = COORD_BITS + FRAC_BITS;

	// sequencer
	logic [STEP_W-1:0] pc_q, pc_d;
	uword_t            uw;
	logic              cond_ok;

	// request and store state
	logic [SH_W-1:0]       sh_q;
	logic [CNT_W-1:0]      count_q;
	logic                  req_type_q;
	logic [POINT_W-1:0]    px_q;
	logic [POINT_W-1:0]    py_q;
	logic [T_W-1:0]        t_q;
	logic                  req_acc;
	logic                  not_eval;
	logic                  add_ok;
	logic [SH_W-1:0]       y_flip;
	logic [COORD_BITS+POINT_W-1:0] x_ext;
	logic [COORD_BITS+SH_W-1:0]    y_ext;

	logic [2*COORD_BITS-1:0] ctrl_mem [MAX_POINTS];
	logic [2*W-1:0]          work_mem [MAX_POINTS];

	// round control
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] rounds_q;
	logic             first_q;
	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;

	// read stage
	logic                    v_s1;
	logic                    lerp_s1;
	logic                    first_s1;
	logic [IDX_W-1:0]        dst_s1;
	logic [2*COORD_BITS-1:0] ctrl_rd_s1;
	logic [2*W-1:0]          work_rd_s1;
	logic [W-1:0]            a_x_q, a_y_q;
	logic [W-1:0]            b_x, b_y;
	logic signed [W:0]       diff_x, diff_y;

	// multiply stage
	logic                     v_s2;
	logic [IDX_W-1:0]         dst_s2;
	logic [W-1:0]             a_x_s2, a_y_s2;
	logic signed [W+18:0]     prod_x_s2, prod_y_s2;
	logic signed [W+2:0]      sum_x, sum_y;
	logic [W-1:0]             new_x, new_y;

	// result and output word
	logic [W-1:0]          res_x_q, res_y_q;
	logic [STATUS_W-1:0]   res_status_q;
	logic                  out_valid_q;
	logic                  out_free;
	logic [CURVE_W-1:0]    curve_x_q, curve_y_q;
	logic [STATUS_W-1:0]   status_q;
	logic [HELD_W-1:0]     held_q;
	logic [W+CURVE_W-1:0]  cx_ext, cy_ext;
	logic [CNT_W+HELD_W-1:0] held_ext;

	// ---------------------------------------------------------------- sequencer
	assign uw      = ucode_rom(pc_q);
	assign req_acc = req.valid && req.ready;
	assign req.ready = (pc_q == STEP_IDLE);

	assign not_eval = (req_type_q == REQ_ADD) || (count_q <= CNT_W'(2));
	assign add_ok   = (req_type_q == REQ_ADD) && (count_q < CNT_W'(MAX_POINTS));
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		unique case (uw.cond)
			C_NEXT:        cond_ok = 1'b0;
			C_ALWAYS:      cond_ok = 1'b1;
			C_ACCEPT:      cond_ok = req_acc;
			C_NOT_EVAL:    cond_ok = not_eval;
			C_IDX_LAST:    cond_ok = (idx_q == rounds_q);
			C_MORE_ROUNDS: cond_ok = (rounds_q != IDX_W'(1));
			C_OUT_FREE:    cond_ok = out_free;
			default:       cond_ok = 1'b0;
		endcase
		if (cond_ok) begin
			pc_d = uw.target;
		end else if (uw.hold) begin
			pc_d = pc_q;
		end else begin
			pc_d = pc_q + STEP_W'(1);
		end
	end

	assign rd_en  = (uw.op == OP_ISSUE_A) || (uw.op == OP_ISSUE_LERP);
	assign rd_idx = (uw.op == OP_ISSUE_A) ? '0 : idx_q;

	// ---------------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			sh_q        <= SH_RESET;
			count_q     <= '0;
			idx_q       <= '0;
			rounds_q    <= '0;
			first_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (psel && penable && pwrite && pready &&
				paddr[APB_ADDR_W-1] == REG_WIN_HEIGHT) begin
				sh_q <= pwdata[SH_W-1:0];
			end
			if (uw.op == OP_DECODE) begin
				if (add_ok) begin
					count_q <= count_q + CNT_W'(1);
				end
				rounds_q <= IDX_W'(count_q - CNT_W'(1));
				first_q  <= 1'b1;
			end
			if (uw.op == OP_ISSUE_A) begin
				idx_q <= IDX_W'(1);
			end else if (uw.op == OP_ISSUE_LERP) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (uw.op == OP_NEXT_ROUND) begin
				rounds_q <= rounds_q - IDX_W'(1);
				first_q  <= 1'b0;
			end
			v_s1 <= rd_en;
			v_s2 <= v_s1 && lerp_s1;
			if (uw.op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- request capture
	assign y_flip = (py_q > sh_q) ? '0 : sh_q - py_q;
	assign x_ext  = {{COORD_BITS{1'b0}}, px_q};
	assign y_ext  = {{COORD_BITS{1'b0}}, y_flip};

	always_ff @(posedge clk) begin
		if (req_acc) begin
			req_type_q <= req.req_type;
			px_q       <= req.point_x;
			py_q       <= req.point_y;
			t_q        <= (req.t_frac > T_ONE) ? T_ONE : req.t_frac;
		end
		if (uw.op == OP_DECODE && add_ok) begin
			ctrl_mem[count_q[IDX_W-1:0]] <= {x_ext[COORD_BITS-1:0], y_ext[COORD_BITS-1:0]};
		end
	end

	// ---------------------------------------------------------------- lerp datapath
	// round one reads the control points straight from the store
	assign b_x = first_s1 ? {ctrl_rd_s1[2*COORD_BITS-1:COORD_BITS], {FRAC_BITS{1'b0}}}
		: work_rd_s1[2*W-1:W];
	assign b_y = first_s1 ? {ctrl_rd_s1[COORD_BITS-1:0], {FRAC_BITS{1'b0}}}
		: work_rd_s1[W-1:0];

	assign diff_x = $signed({1'b0, b_x}) - $signed({1'b0, a_x_q});
	assign diff_y = $signed({1'b0, b_y}) - $signed({1'b0, a_y_q});

	// arithmetic shift of the product gives the floor
	assign sum_x = $signed({3'b000, a_x_s2}) + $signed(prod_x_s2[W+18:16]);
	assign sum_y = $signed({3'b000, a_y_s2}) + $signed(prod_y_s2[W+18:16]);
	assign new_x = sum_x[W-1:0];
	assign new_y = sum_y[W-1:0];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			ctrl_rd_s1 <= ctrl_mem[rd_idx];
			work_rd_s1 <= work_mem[rd_idx];
			lerp_s1    <= (uw.op == OP_ISSUE_LERP);
			first_s1   <= first_q;
			dst_s1     <= rd_idx - IDX_W'(1);
		end
		if (v_s1) begin
			a_x_q <= b_x;
			a_y_q <= b_y;
			if (lerp_s1) begin
				prod_x_s2 <= (W+19)'(diff_x) * (W+19)'($signed({1'b0, t_q}));
				prod_y_s2 <= (W+19)'(diff_y) * (W+19)'($signed({1'b0, t_q}));
				a_x_s2    <= a_x_q;
				a_y_s2    <= a_y_q;
				dst_s2    <= dst_s1;
			end
		end
		if (v_s2) begin
			work_mem[dst_s2] <= {new_x, new_y};
			if (rounds_q == IDX_W'(1)) begin
				res_x_q <= new_x;
				res_y_q <= new_y;
			end
		end
		if (uw.op == OP_DECODE) begin
			if (not_eval) begin
				res_x_q <= '0;
				res_y_q <= '0;
			end
			if (req_type_q == REQ_ADD) begin
				res_status_q <= add_ok ? ST_OK : ST_FULL;
			end else begin
				res_status_q <= not_eval ? ST_FEW : ST_OK;
			end
		end
	end

	// ---------------------------------------------------------------- output word
	assign cx_ext   = {{CURVE_W{1'b0}}, res_x_q};
	assign cy_ext   = {{CURVE_W{1'b0}}, res_y_q};
	assign held_ext = {{HELD_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (uw.op == OP_EMIT && out_free) begin
			curve_x_q <= cx_ext[CURVE_W-1:0];
			curve_y_q <= cy_ext[CURVE_W-1:0];
			status_q  <= res_status_q;
			held_q    <= held_ext[HELD_W-1:0];
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.curve_x     = curve_x_q;
	assign rsp.curve_y     = curve_y_q;
	assign rsp.status      = status_q;
	assign rsp.points_held = held_q;

	// ---------------------------------------------------------------- register port
	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1] == REG_WIN_HEIGHT)
		? {{(APB_DATA_W-SH_W){1'b0}}, sh_q} : '0;

	// ---------------------------------------------------------------- assertions
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_POINTS))
		else $error("point count beyond store depth");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> pc_q == STEP_DECODE)
		else $error("accepted word not decoded");

	a_write_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> dst_s2 < rounds_q)
		else $error("work write outside current round");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pc_q == STEP_EMIT))
		else $error("response raised outside emit step");

endmodule
